// ----- design/mwo_pkg.sv -----
package mwo_pkg;

  // Sine table size and envelope format.
  localparam int SINE_ADDR_BITS = 10;
  localparam int ENV_FRAC_BITS  = 24;

  // Field widths.
  localparam int SAMPLE_W   = 32;
  localparam int PHASE_W    = 32;
  localparam int ENV_W      = ENV_FRAC_BITS + 1;
  localparam int WAVESEL_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Waveform full scale, 2^31 - 2.
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 32'd2147483646;

  // Envelope value of 1.0.
  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << ENV_FRAC_BITS;

  // Output queue depth; it also sets the number of words in flight. It has
  // to cover the round trip from input accept to output accept so that a
  // word can be taken every cycle while the sink keeps taking words.
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM   = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_ENV_STEP   = 2'd2
  } cfg_index_t;

  // Waveform codes.
  typedef enum logic [WAVESEL_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_sel_t;

  // One sample in flight after the state update.
  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] phase;
    logic [ENV_W-1:0]   env;
  } stage_t;

  // One finished result word.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ENV_W-1:0]    envelope_level;
  } result_t;

endpackage

// ----- design/mwo_in_if.sv -----
interface mwo_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- design/mwo_out_if.sv -----
interface mwo_out_if;
  logic                             valid;
  logic                             ready;
  logic [mwo_pkg::SAMPLE_W-1:0]     sample;
  logic [mwo_pkg::ENV_W-1:0]        envelope_level;

  modport source (output valid, output sample, output envelope_level, input ready);
  modport sink   (input valid, input sample, input envelope_level, output ready);
endinterface

// ----- design/mwo_sine_rom.sv -----
module mwo_sine_rom (
  input  logic                              clk,
  input  logic [mwo_pkg::SINE_ADDR_BITS-1:0] addr,
  output logic [mwo_pkg::SAMPLE_W-1:0]       data
);

  localparam int DEPTH   = 1 << mwo_pkg::SINE_ADDR_BITS;
  localparam int QUARTER = 1 << (mwo_pkg::SINE_ADDR_BITS - 2);
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FULL_Q      = 64'(mwo_pkg::FULL_SCALE);

  typedef logic [mwo_pkg::SAMPLE_W-1:0] rom_t [DEPTH];

  // Taylor divisors for the Horner steps, highest order first.
  localparam longint unsigned SeriesDiv [6] = '{156, 110, 72, 42, 20, 6};

  // |sin| in Q2.30 at quarter-wave position k, clamped to 1.0.
  function automatic longint unsigned quarter_sine(longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned q;
    x  = (k * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int j = 0; j < 6; j++) begin
      q = ((x2 * t) >> 30) / SeriesDiv[j];
      t = (q >= Q30_ONE) ? 64'd0 : (Q30_ONE - q);
    end
    t = (x * t) >> 30;
    return (t > Q30_ONE) ? Q30_ONE : t;
  endfunction

  // Full-wave table entry: full scale plus or minus the scaled sine.
  function automatic rom_t build_table();
    rom_t            tbl;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned k;
    longint unsigned m;
    for (int i = 0; i < DEPTH; i++) begin
      quad = (longint'(i) >> (mwo_pkg::SINE_ADDR_BITS - 2)) & 64'd3;
      r    = longint'(i) & longint'(QUARTER - 1);
      k    = quad[0] ? (longint'(QUARTER) - r) : r;
      m    = (quarter_sine(k) * FULL_Q) >> 30;
      tbl[i] = quad[1] ? mwo_pkg::SAMPLE_W'(FULL_Q - m) : mwo_pkg::SAMPLE_W'(FULL_Q + m);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_TABLE = build_table();

  // Registered read.
  always_ff @(posedge clk) begin
    data <= SINE_TABLE[addr];
  end

endmodule

// ----- design/mwo_shaper.sv -----
module mwo_shaper (
  input  logic                          clk,
  input  logic                          rst,
  input  mwo_pkg::wave_sel_t            waveform,
  input  mwo_pkg::stage_t               stage_in,
  input  logic [mwo_pkg::SAMPLE_W-1:0]  sine_level,
  output logic                          res_valid,
  output mwo_pkg::result_t              res
);

  localparam int PROD_W = mwo_pkg::SAMPLE_W + mwo_pkg::ENV_W;

  logic [mwo_pkg::SAMPLE_W-1:0] wave;
  logic [mwo_pkg::SAMPLE_W-1:0] tri_raw;
  logic [mwo_pkg::SAMPLE_W-1:0] saw_raw;
  logic                         top_bit;

  logic                         w_valid;
  logic [mwo_pkg::SAMPLE_W-1:0] w_val;
  logic [mwo_pkg::ENV_W-1:0]    w_env;
  logic [PROD_W-1:0]            product;

  // Pick the waveform value for the phase of this sample.
  always_comb begin
    top_bit = stage_in.phase[mwo_pkg::PHASE_W-1];
    tri_raw = top_bit ? ~stage_in.phase : stage_in.phase;
    saw_raw = stage_in.phase >> 1;
    case (waveform)
      mwo_pkg::WAVE_SINE:     wave = sine_level;
      mwo_pkg::WAVE_SQUARE:   wave = top_bit ? '0 : mwo_pkg::FULL_SCALE;
      mwo_pkg::WAVE_TRIANGLE: wave = (tri_raw > mwo_pkg::FULL_SCALE) ? mwo_pkg::FULL_SCALE
                                                                      : tri_raw;
      default:                wave = (saw_raw > mwo_pkg::FULL_SCALE) ? mwo_pkg::FULL_SCALE
                                                                      : saw_raw;
    endcase
  end

  // Register the waveform value ahead of the envelope multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= stage_in.valid;
    end
    w_val <= wave;
    w_env <= stage_in.env;
  end

  // Scale by the envelope and keep the integer part.
  assign product = PROD_W'(w_val) * PROD_W'(w_env);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= w_valid;
    end
    res.sample         <= product[mwo_pkg::ENV_FRAC_BITS +: mwo_pkg::SAMPLE_W];
    res.envelope_level <= w_env;
  end

endmodule

// ----- design/mwo_out_fifo.sv -----
module mwo_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mwo_pkg::result_t  push_word,
  mwo_out_if.source         out_ch
);

  mwo_pkg::result_t               mem [mwo_pkg::FIFO_DEPTH];
  logic [mwo_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [mwo_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [mwo_pkg::FIFO_CNT_W-1:0] count;
  logic                           pop;

  assign pop                   = out_ch.valid && out_ch.ready;
  assign out_ch.valid          = (count != '0);
  assign out_ch.sample         = mem[rd_ptr].sample;
  assign out_ch.envelope_level = mem[rd_ptr].envelope_level;

  // Storage; the upstream credit count keeps it from overflowing.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + mwo_pkg::FIFO_CNT_W'(push) - mwo_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

// ----- design/multiwave_oscillator_with_envelope.sv -----
// Multiwave oscillator with a pulse envelope. Every input word yields one
// output word: an unsigned 32-bit sample of the selected waveform (sine from
// a 1024-entry table, square, triangle or sawtooth) taken at the current
// phase and scaled by the Q1.24 envelope, plus the envelope level used. A
// set restart bit clears the phase and reloads the envelope to 1.0 before
// that sample is formed. The block accepts one word per clock while fewer
// than eight words are in flight. A result passes through the state update
// and sine table read, waveform select, envelope multiply and output queue
// registers. The eight-entry output queue sets how many words may be in
// flight; a word taken at the sink frees its slot in the next cycle, so a
// full rate stream keeps one word per cycle as long as the sink takes one
// per cycle. Registers: 0 waveform, 1 phase_step, 2 env_step; write them
// only while no words are in flight.
module multiwave_oscillator_with_envelope (
  input  logic                            clk,
  input  logic                            rst,
  mwo_in_if.sink                          in_ch,
  mwo_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mwo_pkg::wave_sel_t            waveform;
  logic [mwo_pkg::PHASE_W-1:0]   phase_step;
  logic [mwo_pkg::ENV_W-1:0]     env_step;

  logic [mwo_pkg::PHASE_W-1:0]   phase_acc;
  logic [mwo_pkg::ENV_W-1:0]     envelope;
  logic [mwo_pkg::PHASE_W-1:0]   phase_cur;
  logic [mwo_pkg::ENV_W-1:0]     env_cur;
  logic [mwo_pkg::ENV_W-1:0]     envelope_next;

  logic [mwo_pkg::FIFO_CNT_W-1:0] credits;
  logic                           in_fire;
  logic                           out_fire;

  mwo_pkg::stage_t               stage1;
  logic [mwo_pkg::SAMPLE_W-1:0]  sine_level;
  logic                          res_valid;
  mwo_pkg::result_t              res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform   <= mwo_pkg::WAVE_SINE;
      phase_step <= 32'd42852282;
      env_step   <= mwo_pkg::ENV_W'(127);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwo_pkg::CFG_WAVEFORM:   waveform   <= mwo_pkg::wave_sel_t'(cfg_data[mwo_pkg::WAVESEL_W-1:0]);
        mwo_pkg::CFG_PHASE_STEP: phase_step <= cfg_data[mwo_pkg::PHASE_W-1:0];
        mwo_pkg::CFG_ENV_STEP:   env_step   <= cfg_data[mwo_pkg::ENV_W-1:0];
        default: ;
      endcase
    end
  end

  // Words in flight, counted against the output queue depth.
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (credits < mwo_pkg::FIFO_CNT_W'(mwo_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + mwo_pkg::FIFO_CNT_W'(in_fire) - mwo_pkg::FIFO_CNT_W'(out_fire);
    end
  end

  // Phase and envelope seen by this word, after an optional restart.
  always_comb begin
    phase_cur = in_ch.restart ? '0 : phase_acc;
    env_cur   = in_ch.restart ? mwo_pkg::ENV_ONE : envelope;
    envelope_next = (env_step >= env_cur) ? mwo_pkg::ENV_ONE : (env_cur - env_step);
  end

  // Oscillator state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      envelope  <= mwo_pkg::ENV_ONE;
      stage1.valid <= 1'b0;
    end else begin
      stage1.valid <= in_fire;
      if (in_fire) begin
        phase_acc <= phase_cur + phase_step;
        envelope  <= envelope_next;
      end
    end
    stage1.phase <= phase_cur;
    stage1.env   <= env_cur;
  end

  // Sine table read lines up with the first stage register.
  mwo_sine_rom u_sine_rom (
    .clk  (clk),
    .addr (phase_cur[mwo_pkg::PHASE_W-1 -: mwo_pkg::SINE_ADDR_BITS]),
    .data (sine_level)
  );

  mwo_shaper u_shaper (
    .clk        (clk),
    .rst        (rst),
    .waveform   (waveform),
    .stage_in   (stage1),
    .sine_level (sine_level),
    .res_valid  (res_valid),
    .res        (res)
  );

  mwo_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_word (res),
    .out_ch    (out_ch)
  );

endmodule
